[design/atpp_pkg.sv]
// Shared types and constants of the adaptive-threshold peak picker.
package atpp_pkg;

	// Field widths
	localparam int VAL_W     = 16;  // onset strength, unsigned Q0.16
	localparam int CFG_W     = 16;  // configuration register width
	localparam int IDX_W     = 12;  // reported frame index
	localparam int CFG_IDX_W = 1;   // configuration register index

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SENS = 1'b1;

	// Configuration reset values
	localparam logic [CFG_W-1:0] GAIN_RESET = 16'd4096;   // 1.0 in Q4.12
	localparam logic [CFG_W-1:0] SENS_RESET = 16'd32768;  // 0.5 in Q0.16

	// Offset term: sensitivity is Q0.16, gain is Q4.12, so the offset is shifted by 12
	localparam int OFS_SHIFT = 12;

	// Frames skipped after a peak
	localparam int             SKIP_W     = 2;
	localparam logic [SKIP_W-1:0] SKIP_AFTER = 2'd3;

	// Results reported per input frame
	localparam int MAX_RESULTS = 2;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// Result buffer
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = 1;
	localparam int RES_FILL_W = 2;

	// One result item
	typedef struct packed {
		logic [IDX_W-1:0] peak_index;
		logic             last_in_run;
	} res_t;

	// Stage enables of the threshold datapath
	typedef struct packed {
		logic mul_en;
		logic add_en;
	} thr_ctl_t;

endpackage

[design/atpp_ifs.sv]
// Channel interfaces: frame input, peak output and configuration write.
interface atpp_frame_if import atpp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] onset_strength;
	logic             last_frame;

	modport source (output valid, output onset_strength, output last_frame, input ready);
	modport sink   (input valid, input onset_strength, input last_frame, output ready);
endinterface

interface atpp_peak_if import atpp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] peak_index;
	logic             last_in_run;

	modport source (output valid, output peak_index, output last_in_run, input ready);
	modport sink   (input valid, input peak_index, input last_in_run, output ready);
endinterface

interface atpp_cfg_if import atpp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[design/atpp_cell.sv]
// One cell of the frame window: a value and its valid flag, shifted towards the oldest end.
module atpp_cell import atpp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic             clear,
	input  logic [VAL_W-1:0] d_value,
	input  logic             d_valid,
	output logic [VAL_W-1:0] q_value,
	output logic             q_valid
);

	logic [VAL_W-1:0] value_q;
	logic             valid_q;

	// Value register, no reset needed
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= d_value;
		end
	end

	// Valid flag, cleared at sequence end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (clear) begin
				valid_q <= 1'b0;
			end else if (shift) begin
				valid_q <= d_valid;
			end else begin
				valid_q <= valid_q;
			end
		end
	end

	assign q_value = value_q;
	assign q_valid = valid_q;

endmodule

[design/atpp_thresh.sv]
// Threshold datapath: value*count*40960 > sum*gain*10 + sens*count*4096, in three steps.
module atpp_thresh import atpp_pkg::*; #(
	parameter int SUM_W = 20,
	parameter int CNT_W = 4
) (
	input  logic             clk,
	input  thr_ctl_t         ctl,
	input  logic [VAL_W-1:0] x,
	input  logic [SUM_W-1:0] sum,
	input  logic [CNT_W-1:0] count,
	input  logic [CFG_W-1:0] gain,
	input  logic [CFG_W-1:0] sens,
	output logic             pass
);

	localparam int SG_W   = SUM_W + CFG_W;
	localparam int XC_W   = VAL_W + CNT_W;
	localparam int SC_W   = CFG_W + CNT_W;
	localparam int SG10_W = SG_W + 4;
	localparam int XC10_W = XC_W + 4;
	localparam int CMP_W  = SG_W + 5;

	logic [SG_W-1:0]   sg_s1;
	logic [XC_W-1:0]   xc_s1;
	logic [SC_W-1:0]   sc_s1;
	logic [SG10_W-1:0] sg10_s2;
	logic [XC10_W-1:0] xc10_s2;
	logic [SC_W-1:0]   sc_s2;
	logic [CMP_W-1:0]  lhs;
	logic [CMP_W-1:0]  rhs;

	// Step 1: the three products
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			sg_s1 <= SG_W'(sum) * SG_W'(gain);
			xc_s1 <= XC_W'(x) * XC_W'(count);
			sc_s1 <= SC_W'(sens) * SC_W'(count);
		end
	end

	// Step 2: times ten as shift and add
	always_ff @(posedge clk) begin
		if (ctl.add_en) begin
			sg10_s2 <= SG10_W'({sg_s1, 3'b000}) + SG10_W'({sg_s1, 1'b0});
			xc10_s2 <= XC10_W'({xc_s1, 3'b000}) + XC10_W'({xc_s1, 1'b0});
			sc_s2   <= sc_s1;
		end
	end

	// Step 3: offset add and compare
	assign lhs  = CMP_W'({xc10_s2, {OFS_SHIFT{1'b0}}});
	assign rhs  = CMP_W'(sg10_s2) + CMP_W'({sc_s2, {OFS_SHIFT{1'b0}}});
	assign pass = lhs > rhs;

endmodule

[design/atpp_res_buf.sv]
// Two-entry result buffer driving the peak output channel.
module atpp_res_buf import atpp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  res_t  push_data,
	output logic  full,
	atpp_peak_if.source peak_out
);

	res_t                  ent_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]  wr_ptr_q;
	logic [RES_PTR_W-1:0]  rd_ptr_q;
	logic [RES_FILL_W-1:0] fill_q;
	logic                  pop;

	assign pop  = peak_out.valid & peak_out.ready;
	assign full = (fill_q == RES_FILL_W'(RES_DEPTH));

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + RES_FILL_W'(push) - RES_FILL_W'(pop);
		end
	end

	assign peak_out.valid       = (fill_q != '0);
	assign peak_out.peak_index  = ent_q[rd_ptr_q].peak_index;
	assign peak_out.last_in_run = ent_q[rd_ptr_q].last_in_run;

endmodule

[design/adaptive_threshold_peak_picker.sv]
// Onset peak picker: each frame is held in a row of window cells and judged against a
// centred moving average of up to 2*(AVG_WINDOW/2)+1 frames once AVG_WINDOW/2 later frames
// have arrived or the sequence ends; a peak must beat gain*average + 0.1*sensitivity and
// both neighbours, and the next three frames are then passed over. A new frame is taken
// only once the previous one is through the sequencer; after the frame marked last, the
// frames above the centre cell but the last are shifted to it one at a time. Each judged
// frame passes through the multiply, scale and compare steps of the shared datapath. Up to
// two peak indexes per frame leave through a two-entry buffer, the last one flagged; a full
// buffer holds the sequencer. Registers may be written whenever no frame is in flight.
module adaptive_threshold_peak_picker import atpp_pkg::*; #(
	parameter int AVG_WINDOW = 10,
	parameter int MAX_FRAMES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	atpp_frame_if.sink  frame_in,
	atpp_peak_if.source peak_out,
	atpp_cfg_if.sink    cfg_wr
);

	localparam int HALF      = AVG_WINDOW / 2;
	localparam int DEPTH     = 2 * HALF + 1;
	localparam int SUM_W     = VAL_W + $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int FRAME_CAP = MAX_FRAMES + 2 * HALF;
	localparam int POS_W     = $clog2(FRAME_CAP + 1);
	localparam int FL_W      = $clog2(HALF + 1);
	localparam int IDX_MAX   = MAX_FRAMES - 1;

	// Sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [POS_W-1:0]     pos_q;
	logic [SKIP_W-1:0]    skip_q;
	logic [FL_W-1:0]      flush_q;
	logic                 last_seq_q;
	logic [RES_CNT_W-1:0] nres_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic                 have_pend_q;
	logic [CFG_W-1:0]     gain_q;
	logic [CFG_W-1:0]     sens_q;

	logic [VAL_W-1:0] tap_val [DEPTH+1];
	logic             tap_vld [DEPTH+1];

	logic             in_acc;
	logic             flush_shift;
	logic             shift_en;
	logic             clear_seq;
	logic [VAL_W-1:0] out0_val;
	logic             thr_pass;
	thr_ctl_t         thr_ctl;
	logic             eligible;
	logic             is_peak;
	logic             take;
	logic             cmp_stall;
	logic             done_stall;
	logic             buf_full;
	logic             buf_push;
	res_t             buf_data;
	logic [POS_W-1:0] idx_full;
	logic [POS_W-1:0] idx_sat;

	// Configuration registers
	assign cfg_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			sens_q <= SENS_RESET;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				REG_GAIN: gain_q <= cfg_wr.data;
				REG_SENS: sens_q <= cfg_wr.data;
				default:  gain_q <= gain_q;
			endcase
		end
	end

	// Handshake and shift control
	assign frame_in.ready = (state_q == ST_IDLE);
	assign in_acc         = frame_in.valid & frame_in.ready;
	assign shift_en       = in_acc | flush_shift;

	// Window chain: newest at the top, oldest in cell 0; flush shifts feed empty slots
	assign tap_val[DEPTH] = in_acc ? frame_in.onset_strength : '0;
	assign tap_vld[DEPTH] = in_acc;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		atpp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift_en),
			.clear   (clear_seq),
			.d_value (tap_val[i+1]),
			.d_valid (tap_vld[i+1]),
			.q_value (tap_val[i]),
			.q_valid (tap_vld[i])
		);
	end

	assign out0_val = tap_vld[0] ? tap_val[0] : '0;

	// Threshold datapath on the centre cell
	assign thr_ctl.mul_en = (state_q == ST_MUL);
	assign thr_ctl.add_en = (state_q == ST_ADD);

	atpp_thresh #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_thresh (
		.clk   (clk),
		.ctl   (thr_ctl),
		.x     (tap_val[HALF]),
		.sum   (sum_q),
		.count (cnt_q),
		.gain  (gain_q),
		.sens  (sens_q),
		.pass  (thr_pass)
	);

	// Frame index of the centre cell, saturated
	assign idx_full = pos_q - POS_W'(HALF + 1);
	assign idx_sat  = (idx_full > POS_W'(IDX_MAX)) ? POS_W'(IDX_MAX) : idx_full;

	// Peak decision; the first frame of a sequence is never judged
	assign eligible = tap_vld[HALF] & tap_vld[HALF-1];
	assign is_peak  = eligible && (skip_q == '0) && thr_pass
	                  && (tap_val[HALF] > tap_val[HALF-1])
	                  && (tap_val[HALF] > tap_val[HALF+1]);
	assign take     = is_peak && (nres_q < RES_CNT_W'(MAX_RESULTS));

	// A new peak pushes the one held before it; the held one goes out flagged at the end
	assign cmp_stall   = take && have_pend_q && buf_full;
	assign done_stall  = have_pend_q && buf_full;
	assign flush_shift = (state_q == ST_CMP) && !cmp_stall && (flush_q != '0);
	assign clear_seq   = (state_q == ST_DONE) && !done_stall && last_seq_q;

	always_comb begin
		buf_push             = 1'b0;
		buf_data.peak_index  = pend_idx_q;
		buf_data.last_in_run = 1'b0;
		if (state_q == ST_CMP) begin
			buf_push = take && have_pend_q && !buf_full;
		end else if (state_q == ST_DONE) begin
			buf_push             = have_pend_q && !buf_full;
			buf_data.last_in_run = 1'b1;
		end
	end

	atpp_res_buf u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (buf_push),
		.push_data (buf_data),
		.full      (buf_full),
		.peak_out  (peak_out)
	);

	// Running window sum, frame count in window and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			priority if (clear_seq) begin
				sum_q <= '0;
				cnt_q <= '0;
				pos_q <= '0;
			end else if (shift_en) begin
				sum_q <= sum_q - SUM_W'(out0_val) + SUM_W'(tap_val[DEPTH]);
				cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(tap_vld[0]);
				if (pos_q != POS_W'(FRAME_CAP)) begin
					pos_q <= pos_q + 1'b1;
				end
			end else begin
				sum_q <= sum_q;
				cnt_q <= cnt_q;
				pos_q <= pos_q;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			skip_q      <= '0;
			flush_q     <= '0;
			last_seq_q  <= 1'b0;
			nres_q      <= '0;
			have_pend_q <= 1'b0;
			pend_idx_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_seq_q <= frame_in.last_frame;
						flush_q    <= frame_in.last_frame ? FL_W'(HALF - 1) : '0;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!cmp_stall) begin
						if (eligible) begin
							priority if (skip_q != '0) begin
								skip_q <= skip_q - 1'b1;
							end else if (is_peak) begin
								skip_q <= SKIP_AFTER;
							end else begin
								skip_q <= skip_q;
							end
						end
						if (take) begin
							pend_idx_q  <= IDX_W'(idx_sat);
							have_pend_q <= 1'b1;
							nres_q      <= nres_q + 1'b1;
						end
						if (flush_q != '0) begin
							flush_q <= flush_q - 1'b1;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!done_stall) begin
						have_pend_q <= 1'b0;
						nres_q      <= '0;
						if (last_seq_q) begin
							skip_q     <= '0;
							last_seq_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/atpp_checker.sv]
// Port-level checks of the peak picker and their binding to the top level.
module atpp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);

	logic out_acc;
	logic run_open_q;

	assign out_acc = out_valid & out_ready;

	// Tracks a result run that has not yet seen its flagged final transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
		end else if (out_acc) begin
			run_open_q <= !out_last;
		end
	end

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("peak output dropped while stalled");

	// At most two results per frame: the one after an unflagged result is flagged
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && run_open_q |-> out_last)
		else $error("result run longer than two transactions");

	// One frame at a time: no frame is taken in the cycle after a frame transaction
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("frame taken while the previous one is in progress");

	// Nothing is offered while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("peak output valid during reset");

endmodule

bind adaptive_threshold_peak_picker atpp_checker u_atpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.out_valid (peak_out.valid),
	.out_ready (peak_out.ready),
	.out_last  (peak_out.last_in_run)
);
